[src/vlprb_pkg.sv]
// ----------------------------------------------------------------------------
// vlprb_pkg
// Shared types and constants of the variable-length packet ring buffer.
// ----------------------------------------------------------------------------
package vlprb_pkg;

	// Default ring size in bytes and header size in bytes
	localparam int STORE_BYTES_DEF  = 1024;
	localparam int HEADER_BYTES_DEF = 8;

	// Header bytes that carry fields: address 4, port 2, length 2
	localparam int HDR_FIELD_BYTES = 8;

	// Field widths
	localparam int ADDR_W = 32;
	localparam int PORT_W = 16;
	localparam int LEN_W  = 10;
	localparam int BYTE_W = 8;

	// Item codes
	typedef enum logic [2:0] {
		K_PUSH_HDR  = 3'd0,
		K_PUSH_BYTE = 3'd1,
		K_READ_HDR  = 3'd2,
		K_READ_BYTE = 3'd3,
		K_POP       = 3'd4
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOSPACE = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_IGNORED = 2'd3
	} stat_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_HDR  = 2'd1,
		S_RDB  = 2'd2,
		S_POP  = 2'd3
	} state_t;

endpackage

[src/variable_length_packet_ring_buffer_unit.sv]
// ----------------------------------------------------------------------------
// variable_length_packet_ring_buffer_unit
// Byte ring of packets (header then payload) with push, read and pop items.
//
//   channel  handshake        payload
//   item     start / busy     kind, in_address, in_port, in_length,
//                             in_byte, byte_offset
//   result   done (1 cycle)   status, front_address, front_port,
//                             front_length, out_byte, is_empty
//
// Push byte, read header and rejected or trivial items finish from the idle
// state; read byte does one registered memory read; push header does one
// memory write per header byte; pop finishes from the idle state, or once the
// next front header is fetched byte by byte through the memory read port.
// Reset clears pointers, the open packet and the cached front header; the
// ring memory itself is not cleared. The done beat cannot be stalled.
// ----------------------------------------------------------------------------
module variable_length_packet_ring_buffer_unit
	import vlprb_pkg::*;
#(
	parameter int STORE_BYTES  = STORE_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        kind,
	input  logic [ADDR_W-1:0] in_address,
	input  logic [PORT_W-1:0] in_port,
	input  logic [LEN_W-1:0]  in_length,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic [LEN_W-1:0]  byte_offset,
	output logic              done,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] front_address,
	output logic [PORT_W-1:0] front_port,
	output logic [LEN_W-1:0]  front_length,
	output logic [BYTE_W-1:0] out_byte,
	output logic              is_empty
);

	localparam int PW = $clog2(STORE_BYTES);

	logic          ram_we, ram_re;
	logic [PW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	// Sequencer
	vlprb_ctrl #(
		.STORE_BYTES  (STORE_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.in_address    (in_address),
		.in_port       (in_port),
		.in_length     (in_length),
		.in_byte       (in_byte),
		.byte_offset   (byte_offset),
		.done          (done),
		.status        (status),
		.front_address (front_address),
		.front_port    (front_port),
		.front_length  (front_length),
		.out_byte      (out_byte),
		.is_empty      (is_empty),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

	// Ring storage
	vlprb_ram #(
		.DEPTH (STORE_BYTES),
		.AW    (PW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

[src/vlprb_ram.sv]
// ----------------------------------------------------------------------------
// vlprb_ram
// Byte-wide ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vlprb_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// Write one byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one byte, hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/vlprb_ctrl.sv]
// ----------------------------------------------------------------------------
// vlprb_ctrl
// Sequencer of the packet ring: ring pointers, staged packet, cached front
// header, and the read/write schedule of the byte memory.
// ----------------------------------------------------------------------------
module vlprb_ctrl
	import vlprb_pkg::*;
#(
	parameter int STORE_BYTES  = STORE_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	localparam int PW = $clog2(STORE_BYTES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        kind,
	input  logic [ADDR_W-1:0] in_address,
	input  logic [PORT_W-1:0] in_port,
	input  logic [LEN_W-1:0]  in_length,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic [LEN_W-1:0]  byte_offset,
	output logic              done,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] front_address,
	output logic [PORT_W-1:0] front_port,
	output logic [LEN_W-1:0]  front_length,
	output logic [BYTE_W-1:0] out_byte,
	output logic              is_empty,
	// byte memory port
	output logic              ram_we,
	output logic [PW-1:0]     ram_waddr,
	output logic [7:0]        ram_wdata,
	output logic              ram_re,
	output logic [PW-1:0]     ram_raddr,
	input  logic [7:0]        ram_rdata
);

	localparam int CW  = ((PW > LEN_W + 1) ? PW : LEN_W + 1) + 1;
	localparam int HW  = HEADER_BYTES * 8;
	localparam int HCW = $clog2(HEADER_BYTES);
	localparam int FW  = HDR_FIELD_BYTES * 8;
	localparam logic [CW-1:0] S_C  = CW'(STORE_BYTES);
	localparam logic [CW-1:0] HB_C = CW'(HEADER_BYTES);

	// Ring-wrapped pointer add, valid for n below the ring size
	function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p,
			input logic [CW-1:0] n);
		logic [CW-1:0] sum;
		sum = CW'(p) + n;
		if (sum >= S_C) begin
			sum = sum - S_C;
		end
		return sum[PW-1:0];
	endfunction

	state_t            state_q, state_d;
	logic [PW-1:0]     rp_q, wp_q, stg_q, wa_q, ra_q;
	logic [LEN_W-1:0]  pending_q;
	logic              open_q;
	logic [HW-1:0]     hdr_q;
	logic [HCW-1:0]    cnt_q;
	logic [3:0]        iss_q;
	logic [2:0]        got_q;
	logic              rv_s1;
	logic [FW-1:0]     asm_q;
	logic [ADDR_W-1:0] stg_addr_q, faddr_q;
	logic [PORT_W-1:0] stg_port_q, fport_q;
	logic [LEN_W-1:0]  stg_len_q, flen_q;
	logic              done_q;
	stat_t             status_q, fin_status;
	logic [BYTE_W-1:0] ob_q;
	logic              fin;

	logic              empty;
	logic [CW-1:0]     used, free_b, need;
	logic              no_space, offs_bad;
	logic [PW-1:0]     pop_rp, rdb_addr, stg_next, hdr_end, wa_next, ra_next;
	logic [FW-1:0]     asm_nx;

	// Pointer arithmetic and checks
	always_comb begin
		empty    = (rp_q == wp_q);
		used     = (wp_q >= rp_q) ? (CW'(wp_q) - CW'(rp_q)) : (CW'(wp_q) + S_C - CW'(rp_q));
		free_b   = S_C - CW'(1) - used;
		need     = HB_C + CW'(in_length);
		no_space = (need > free_b);
		offs_bad = (byte_offset >= flen_q);
		pop_rp   = wrap_add(rp_q, HB_C + CW'(flen_q));
		rdb_addr = wrap_add(rp_q, HB_C + CW'(byte_offset));
		stg_next = wrap_add(stg_q, CW'(1));
		hdr_end  = wrap_add(wp_q, HB_C);
		wa_next  = wrap_add(wa_q, CW'(1));
		ra_next  = wrap_add(ra_q, CW'(1));
		asm_nx   = {ram_rdata, asm_q[FW-1:8]};
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory schedule, finish strobe
	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_waddr  = stg_q;
		ram_wdata  = in_byte;
		ram_re     = 1'b0;
		ram_raddr  = rdb_addr;
		fin        = 1'b0;
		fin_status = STAT_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (kind)
						K_PUSH_HDR: begin
							if (no_space) begin
								fin        = 1'b1;
								fin_status = STAT_NOSPACE;
							end else begin
								state_d = S_HDR;
							end
						end
						K_PUSH_BYTE: begin
							fin = 1'b1;
							if (!open_q) begin
								fin_status = STAT_IGNORED;
							end else begin
								ram_we = 1'b1;
							end
						end
						K_READ_HDR: begin
							fin        = 1'b1;
							fin_status = empty ? STAT_EMPTY : STAT_OK;
						end
						K_READ_BYTE: begin
							if (empty) begin
								fin        = 1'b1;
								fin_status = STAT_EMPTY;
							end else if (offs_bad) begin
								fin        = 1'b1;
								fin_status = STAT_IGNORED;
							end else begin
								ram_re  = 1'b1;
								state_d = S_RDB;
							end
						end
						K_POP: begin
							if (empty) begin
								fin        = 1'b1;
								fin_status = STAT_EMPTY;
							end else if (pop_rp == wp_q) begin
								fin = 1'b1;
							end else begin
								state_d = S_POP;
							end
						end
						default: begin
							fin        = 1'b1;
							fin_status = STAT_IGNORED;
						end
					endcase
				end
			end
			S_HDR: begin
				ram_we    = 1'b1;
				ram_waddr = wa_q;
				ram_wdata = hdr_q[7:0];
				if (cnt_q == HCW'(HEADER_BYTES - 1)) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RDB: begin
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			S_POP: begin
				ram_re    = (iss_q != 4'(HDR_FIELD_BYTES));
				ram_raddr = ra_q;
				if (rv_s1 && got_q == 3'(HDR_FIELD_BYTES - 1)) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Pointers, staged packet, front header cache
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q      <= '0;
			wp_q      <= '0;
			stg_q     <= '0;
			pending_q <= '0;
			open_q    <= 1'b0;
			faddr_q   <= '0;
			fport_q   <= '0;
			flen_q    <= '0;
			cnt_q     <= '0;
			iss_q     <= '0;
			got_q     <= '0;
			rv_s1     <= 1'b0;
			done_q    <= 1'b0;
			status_q  <= STAT_OK;
			ob_q      <= '0;
		end else begin
			done_q <= fin;
			rv_s1  <= ram_re && (state_q == S_POP);
			if (fin) begin
				status_q <= fin_status;
				ob_q     <= (state_q == S_RDB) ? ram_rdata : '0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (kind)
							K_PUSH_HDR: begin
								// open a new packet, drop any unfinished one
								if (!no_space) begin
									open_q    <= 1'b0;
									pending_q <= in_length;
									cnt_q     <= '0;
								end
							end
							K_PUSH_BYTE: begin
								// advance staging, commit on last byte
								if (open_q) begin
									stg_q     <= stg_next;
									pending_q <= pending_q - LEN_W'(1);
									if (pending_q == LEN_W'(1)) begin
										wp_q   <= stg_next;
										open_q <= 1'b0;
										if (empty) begin
											faddr_q <= stg_addr_q;
											fport_q <= stg_port_q;
											flen_q  <= stg_len_q;
										end
									end
								end
							end
							K_POP: begin
								// drop the front packet
								if (!empty) begin
									rp_q  <= pop_rp;
									iss_q <= '0;
									got_q <= '0;
									if (pop_rp == wp_q) begin
										faddr_q <= '0;
										fport_q <= '0;
										flen_q  <= '0;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_HDR: begin
					cnt_q <= cnt_q + HCW'(1);
					if (cnt_q == HCW'(HEADER_BYTES - 1)) begin
						stg_q <= hdr_end;
						if (pending_q == '0) begin
							wp_q <= hdr_end;
							if (empty) begin
								faddr_q <= stg_addr_q;
								fport_q <= stg_port_q;
								flen_q  <= stg_len_q;
							end
						end else begin
							open_q <= 1'b1;
						end
					end
				end
				S_POP: begin
					if (ram_re) begin
						iss_q <= iss_q + 4'd1;
					end
					if (rv_s1) begin
						got_q <= got_q + 3'd1;
						if (got_q == 3'(HDR_FIELD_BYTES - 1)) begin
							faddr_q <= asm_nx[ADDR_W-1:0];
							fport_q <= asm_nx[ADDR_W+PORT_W-1:ADDR_W];
							flen_q  <= asm_nx[ADDR_W+PORT_W+LEN_W-1:ADDR_W+PORT_W];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: header bytes, staged fields, address walkers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start && kind == K_PUSH_HDR && !no_space) begin
					hdr_q      <= HW'({6'd0, in_length, in_port, in_address});
					wa_q       <= wp_q;
					stg_addr_q <= in_address;
					stg_port_q <= in_port;
					stg_len_q  <= in_length;
				end
				if (start && kind == K_POP) begin
					ra_q <= pop_rp;
				end
			end
			S_HDR: begin
				hdr_q <= hdr_q >> 8;
				wa_q  <= wa_next;
			end
			S_POP: begin
				if (ram_re) begin
					ra_q <= ra_next;
				end
				if (rv_s1) begin
					asm_q <= asm_nx;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign out_byte      = ob_q;
	assign front_address = faddr_q;
	assign front_port    = fport_q;
	assign front_length  = flen_q;
	assign is_empty      = empty;

	// Results appear only once the sequencer is back at rest
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while sequencer busy");

	// Empty ring reports a cleared front header
	assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (faddr_q == '0 && fport_q == '0 && flen_q == '0))
		else $error("front header not cleared on empty ring");

	// An open packet always owes at least one byte
	assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (pending_q != '0))
		else $error("open packet with no bytes pending");

	// Header fetch never overlaps a memory write
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> !ram_we)
		else $error("memory write during header fetch");

endmodule
